// ----- design/blie_pkg.sv -----
// Shared types and constants for the bounded list engine.
package blie_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int CNT_W        = 7;
	localparam int VAL_W        = 32;
	localparam int POS_W        = 6;
	localparam int OPC_W        = 2;

	localparam logic [OPC_W-1:0] OP_FRONT  = 2'd0;
	localparam logic [OPC_W-1:0] OP_BACK   = 2'd1;
	localparam logic [OPC_W-1:0] OP_DELETE = 2'd2;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_SHR,
		CELL_PUT,
		CELL_SHL,
		CELL_ROT
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t              mode;
		logic signed [VAL_W-1:0] value;
		logic [CNT_W-1:0]        count;
		logic [CNT_W-1:0]        pos;
	} cell_ctrl_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

endpackage

// ----- design/blie_cell.sv -----
// One list slot of the cell chain: holds a value and trades with its neighbors.
module blie_cell #(
	parameter int IDX = 0
) (
	input  logic                                clk,
	input  blie_pkg::cell_ctrl_t                ctrl,
	input  logic signed [blie_pkg::VAL_W-1:0]   left,
	input  logic signed [blie_pkg::VAL_W-1:0]   right,
	input  logic signed [blie_pkg::VAL_W-1:0]   front,
	output logic signed [blie_pkg::VAL_W-1:0]   data
);

	localparam logic [blie_pkg::CNT_W-1:0] MY_IDX = blie_pkg::CNT_W'(IDX);

	logic signed [blie_pkg::VAL_W-1:0] data_q;
	logic signed [blie_pkg::VAL_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		unique case (ctrl.mode)
			blie_pkg::CELL_HOLD: data_d = data_q;
			blie_pkg::CELL_SHR:  data_d = (IDX == 0) ? ctrl.value : left;
			blie_pkg::CELL_PUT: begin
				if (ctrl.count == MY_IDX) begin
					data_d = ctrl.value;
				end
			end
			blie_pkg::CELL_SHL: begin
				if (MY_IDX >= ctrl.pos) begin
					data_d = right;
				end
			end
			blie_pkg::CELL_ROT: begin
				// the tail of the list takes the old front, the rest move forward
				data_d = (MY_IDX == ctrl.count - blie_pkg::CNT_W'(1)) ? front : right;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

// ----- design/bounded_list_insert_delete_engine.sv -----
// Bounded list engine: a chain of slot cells and the request/emit controller.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit values in a chain of cells, front in
// cell 0. A request inserts at the front, inserts at the back or deletes at a position; it is
// applied in the cycle it is accepted, and the whole list is then emitted front to back, one
// element per cycle while the output does not stall, from cell 0 while the chain rotates one
// place, so the list is back in order when the last element leaves. An empty list is emitted
// as a single zero element marked last.
// Inserts into a full list are refused and flagged by dropped; deletes out of range are
// ignored. No new request is taken until the last element of the current run is taken.
module bounded_list_insert_delete_engine #(
	parameter int CAPACITY = blie_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [blie_pkg::OPC_W-1:0]          opcode,
	input  logic signed [blie_pkg::VAL_W-1:0]   value,
	input  logic [blie_pkg::POS_W-1:0]          position,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [blie_pkg::VAL_W-1:0]   element,
	output logic                                last,
	output logic                                empty_res,
	output logic                                dropped
);

	localparam logic [blie_pkg::CNT_W-1:0] CAP = blie_pkg::CNT_W'(CAPACITY);

	blie_pkg::state_t     state_q;
	blie_pkg::state_t     state_d;
	logic [blie_pkg::CNT_W-1:0] count_q;
	logic [blie_pkg::CNT_W-1:0] emit_q;
	logic                 drop_q;

	logic                 in_acc;
	logic                 out_acc;
	logic                 full;
	logic                 is_ins;
	logic                 del_ok;
	logic [blie_pkg::CNT_W-1:0] pos_ext;
	blie_pkg::cell_ctrl_t ctrl;

	logic signed [blie_pkg::VAL_W-1:0] cell_data [CAPACITY];

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign full    = (count_q >= CAP);
	assign pos_ext = blie_pkg::CNT_W'(position);
	assign is_ins  = (opcode == blie_pkg::OP_FRONT) || (opcode == blie_pkg::OP_BACK);
	assign del_ok  = (opcode == blie_pkg::OP_DELETE) && (pos_ext < count_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			blie_pkg::ST_IDLE: if (in_acc) state_d = blie_pkg::ST_EMIT;
			blie_pkg::ST_EMIT: if (out_acc && last) state_d = blie_pkg::ST_IDLE;
			default:           state_d = blie_pkg::ST_IDLE;
		endcase
	end

	// outputs and cell control
	always_comb begin
		in_stall   = (state_q != blie_pkg::ST_IDLE);
		out_valid  = (state_q == blie_pkg::ST_EMIT);
		empty_res  = (count_q == '0);
		element    = empty_res ? '0 : cell_data[0];
		last       = empty_res || (emit_q == count_q - blie_pkg::CNT_W'(1));
		dropped    = drop_q;
		ctrl.mode  = blie_pkg::CELL_HOLD;
		ctrl.value = value;
		ctrl.count = count_q;
		ctrl.pos   = pos_ext;
		unique case (state_q)
			blie_pkg::ST_IDLE: begin
				if (in_acc) begin
					priority if (is_ins && !full) begin
						ctrl.mode = (opcode == blie_pkg::OP_FRONT) ?
							blie_pkg::CELL_SHR : blie_pkg::CELL_PUT;
					end else if (del_ok) begin
						ctrl.mode = blie_pkg::CELL_SHL;
					end else begin
						ctrl.mode = blie_pkg::CELL_HOLD;
					end
				end
			end
			blie_pkg::ST_EMIT: begin
				if (out_acc && !empty_res) begin
					ctrl.mode = blie_pkg::CELL_ROT;
				end
			end
			default: ctrl.mode = blie_pkg::CELL_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blie_pkg::ST_IDLE;
			count_q <= '0;
			emit_q  <= '0;
			drop_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				emit_q <= '0;
				drop_q <= is_ins && full;
				priority if (is_ins && !full) begin
					count_q <= count_q + blie_pkg::CNT_W'(1);
				end else if (del_ok) begin
					count_q <= count_q - blie_pkg::CNT_W'(1);
				end
			end else if (out_acc) begin
				emit_q <= emit_q + blie_pkg::CNT_W'(1);
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [blie_pkg::VAL_W-1:0] left_v;
		logic signed [blie_pkg::VAL_W-1:0] right_v;
		if (i == 0) begin : g_first
			assign left_v = value;
		end else begin : g_mid_l
			assign left_v = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			// nothing beyond the tail; it holds itself
			assign right_v = cell_data[i];
		end else begin : g_mid_r
			assign right_v = cell_data[i+1];
		end
		blie_cell #(
			.IDX(i)
		) u_cell (
			.clk  (clk),
			.ctrl (ctrl),
			.left (left_v),
			.right(right_v),
			.front(cell_data[0]),
			.data (cell_data[i])
		);
	end

endmodule

// ----- design/blie_checker.sv -----
// Port-level checks for the bounded list engine, bound to the top level.
module blie_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [blie_pkg::VAL_W-1:0]   element,
	input logic                                last,
	input logic                                empty_res,
	input logic                                dropped
);

	// no new request while a run is still being emitted
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !out_valid)
		else $error("request accepted during emission");

	// every request starts a run in the next cycle
	a_run_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (out_valid && in_stall))
		else $error("request produced no run");

	a_empty_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && empty_res) |-> (last && element == '0))
		else $error("empty result not single or not zero");

	// flags hold for the whole run
	a_run_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=> (out_valid && $stable(dropped) && !empty_res))
		else $error("run flags changed mid run");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(element) && $stable(last)))
		else $error("stalled result changed");

endmodule

bind bounded_list_insert_delete_engine blie_checker u_blie_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.element  (element),
	.last     (last),
	.empty_res(empty_res),
	.dropped  (dropped)
);
